// ----- hdl/mkced_pkg.sv -----
// ----------------------------------------------------------------------------
// Multi-key click event detector package
// Shared types, command codes, flag bits, phase codes and reset values.
// ----------------------------------------------------------------------------
package mkced_pkg;

  localparam int NUM_KEYS_DEF = 3;
  localparam int LEVEL_W      = 3;
  localparam int FLAG_W       = 7;
  localparam int CNT_W        = 16;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_CHECK = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd0;
  localparam logic [1:0] REG_LONG_PRESS    = 2'd1;
  localparam logic [1:0] REG_DOUBLE_CLICK  = 2'd2;
  localparam logic [1:0] REG_REPEAT        = 2'd3;

  localparam logic [7:0]       SAMPLE_PERIOD_RST = 8'd20;
  localparam logic [CNT_W-1:0] LONG_PRESS_RST    = 16'd2000;
  localparam logic [CNT_W-1:0] DOUBLE_CLICK_RST  = 16'd200;
  localparam logic [CNT_W-1:0] REPEAT_RST        = 16'd100;

  localparam logic [FLAG_W-1:0] FL_HOLD   = 7'h01;
  localparam logic [FLAG_W-1:0] FL_DOWN   = 7'h02;
  localparam logic [FLAG_W-1:0] FL_UP     = 7'h04;
  localparam logic [FLAG_W-1:0] FL_SINGLE = 7'h08;
  localparam logic [FLAG_W-1:0] FL_DOUBLE = 7'h10;
  localparam logic [FLAG_W-1:0] FL_LONG   = 7'h20;
  localparam logic [FLAG_W-1:0] FL_REPEAT = 7'h40;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_PRESSED  = 3'd1;
  localparam logic [2:0] PH_RELEASED = 3'd2;
  localparam logic [2:0] PH_DOUBLE   = 3'd3;
  localparam logic [2:0] PH_LONG     = 3'd4;

  typedef struct packed {
    logic              tick;
    logic              sample;
    logic              check;
    logic              clear;
    logic [FLAG_W-1:0] mask;
  } lane_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] long_press;
    logic [CNT_W-1:0] double_click;
    logic [CNT_W-1:0] repeat_gap;
  } timing_t;

endpackage

// ----- hdl/multi_key_click_event_detector_unit.sv -----
// ----------------------------------------------------------------------------
// Multi-key click event detector
// Turns sampled key levels into sticky click, hold and repeat event flags.
//
//   channel  handshake               payload
//   in       in_valid / in_stall     cmd, key_levels, key_sel, flag_mask
//   out      out_valid / out_stall   hit, flags
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Every item yields one result item in the cycle after it is taken.
// All key lanes update in the same cycle, so one item is taken per cycle unless a result stalls.
// A stalled result holds the input side until it is taken.
// Reset clears all key state and loads the default timing registers.
// ----------------------------------------------------------------------------
module multi_key_click_event_detector_unit #(
  parameter int NUM_KEYS = mkced_pkg::NUM_KEYS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       cmd,
  input  logic [mkced_pkg::LEVEL_W-1:0]    key_levels,
  input  logic [1:0]                       key_sel,
  input  logic [mkced_pkg::FLAG_W-1:0]     flag_mask,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             hit,
  output logic [mkced_pkg::FLAG_W-1:0]     flags,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [mkced_pkg::CNT_W-1:0]      cfg_data
);
  import mkced_pkg::*;

  logic                           accept;
  logic [7:0]                     sample_period;
  timing_t                        timing;
  logic [7:0]                     prescale_count;
  logic [8:0]                     prescale_inc;
  logic                           sample;
  lane_ctrl_t                     ctrl;
  logic [NUM_KEYS-1:0][FLAG_W-1:0] lane_flags;

  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period       <= SAMPLE_PERIOD_RST;
      timing.long_press   <= LONG_PRESS_RST;
      timing.double_click <= DOUBLE_CLICK_RST;
      timing.repeat_gap   <= REPEAT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SAMPLE_PERIOD: sample_period       <= cfg_data[7:0];
        REG_LONG_PRESS:    timing.long_press   <= cfg_data;
        REG_DOUBLE_CLICK:  timing.double_click <= cfg_data;
        REG_REPEAT:        timing.repeat_gap   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign prescale_inc = {1'b0, prescale_count} + 9'd1;
  assign sample       = prescale_inc >= {1'b0, sample_period};

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
    end else if (accept && (cmd == CMD_TICK)) begin
      prescale_count <= sample ? '0 : prescale_inc[7:0];
    end
  end

  always_comb begin
    ctrl.tick   = accept && (cmd == CMD_TICK);
    ctrl.sample = sample;
    ctrl.check  = 1'b0;
    ctrl.clear  = accept && (cmd == CMD_CLEAR);
    ctrl.mask   = flag_mask;
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    lane_ctrl_t lctrl;
    logic       level;

    always_comb begin
      lctrl       = ctrl;
      lctrl.check = accept && (cmd == CMD_CHECK) && (32'(key_sel) == k);
    end

    if (k < LEVEL_W) begin : g_lvl
      assign level = key_levels[k];
    end else begin : g_nolvl
      assign level = 1'b0;
    end

    mkced_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (lctrl),
      .timing (timing),
      .level  (level),
      .flags  (lane_flags[k])
    );
  end

  mkced_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cmd        (cmd),
    .key_sel    (key_sel),
    .flag_mask  (flag_mask),
    .lane_flags (lane_flags),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .hit        (hit),
    .flags      (flags)
  );

`ifndef NO_ASSERTIONS
  a_hit_has_flags: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (flags != '0))
    else $error("hit reported with no flags set");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_CLEAR)) |=> (lane_flags == '0))
    else $error("clear item left flags set");
`endif

endmodule

// ----- hdl/mkced_lane.sv -----
// ----------------------------------------------------------------------------
// Key lane
// Countdown, sampled level, phase machine and sticky event flags of one key.
// ----------------------------------------------------------------------------
module mkced_lane (
  input  logic                      clk,
  input  logic                      rst,
  input  mkced_pkg::lane_ctrl_t     ctrl,
  input  mkced_pkg::timing_t        timing,
  input  logic                      level,
  output logic [mkced_pkg::FLAG_W-1:0] flags
);
  import mkced_pkg::*;

  logic [2:0]        phase;
  logic [2:0]        phase_next;
  logic [CNT_W-1:0]  countdown;
  logic [CNT_W-1:0]  countdown_next;
  logic [CNT_W-1:0]  cd_dec;
  logic              curr_level;
  logic              curr_level_next;
  logic [FLAG_W-1:0] flags_next;

  always_comb begin
    cd_dec          = (countdown != '0) ? countdown - CNT_W'(1) : countdown;
    phase_next      = phase;
    countdown_next  = countdown;
    curr_level_next = curr_level;
    flags_next      = flags;
    if (ctrl.clear) begin
      flags_next = '0;
    end else if (ctrl.check) begin
      if (((flags & ctrl.mask) != '0) && (ctrl.mask != FL_HOLD)) begin
        flags_next = flags & ~ctrl.mask;
      end
    end else if (ctrl.tick) begin
      countdown_next = cd_dec;
      if (ctrl.sample) begin
        curr_level_next = level;
        unique case (phase)
          PH_IDLE: begin
            if (level) begin
              countdown_next = timing.long_press;
              flags_next     = flags_next | FL_HOLD;
              phase_next     = PH_PRESSED;
              if (!curr_level) flags_next = flags_next | FL_DOWN;
            end
          end
          PH_PRESSED: begin
            if (!level) begin
              countdown_next = timing.double_click;
              flags_next     = flags_next & ~FL_HOLD;
              phase_next     = PH_RELEASED;
              if (curr_level) flags_next = flags_next | FL_UP;
            end else if (cd_dec == '0) begin
              flags_next = flags_next | FL_LONG;
              phase_next = PH_LONG;
            end
          end
          PH_RELEASED: begin
            if (cd_dec == '0) begin
              flags_next = flags_next | FL_SINGLE;
              phase_next = PH_IDLE;
            end else if (level) begin
              flags_next = flags_next | FL_DOUBLE | FL_HOLD;
              phase_next = PH_DOUBLE;
            end
            if (level && !curr_level) flags_next = flags_next | FL_DOWN;
          end
          PH_DOUBLE: begin
            if (!level) begin
              flags_next = flags_next & ~FL_HOLD;
              phase_next = PH_IDLE;
              if (curr_level) flags_next = flags_next | FL_UP;
            end
          end
          PH_LONG: begin
            if (!level) begin
              flags_next = flags_next & ~FL_HOLD;
              phase_next = PH_IDLE;
              if (curr_level) flags_next = flags_next | FL_UP;
            end else if (cd_dec == '0) begin
              countdown_next = timing.repeat_gap;
              flags_next     = flags_next | FL_REPEAT;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      countdown  <= '0;
      curr_level <= 1'b0;
      flags      <= '0;
    end else begin
      phase      <= phase_next;
      countdown  <= countdown_next;
      curr_level <= curr_level_next;
      flags      <= flags_next;
    end
  end

endmodule

// ----- hdl/mkced_merge.sv -----
// ----------------------------------------------------------------------------
// Result merge
// Selects the checked key's flags from all lanes and holds the result item.
// ----------------------------------------------------------------------------
module mkced_merge #(
  parameter int NUM_KEYS = mkced_pkg::NUM_KEYS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      accept,
  input  logic [1:0]                                cmd,
  input  logic [1:0]                                key_sel,
  input  logic [mkced_pkg::FLAG_W-1:0]              flag_mask,
  input  logic [NUM_KEYS-1:0][mkced_pkg::FLAG_W-1:0] lane_flags,
  input  logic                                      out_stall,
  output logic                                      out_valid,
  output logic                                      hit,
  output logic [mkced_pkg::FLAG_W-1:0]              flags
);
  import mkced_pkg::*;

  logic [FLAG_W-1:0] sel_flags;
  logic              sel_ok;

  always_comb begin
    sel_flags = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (32'(key_sel) == k) sel_flags = sel_flags | lane_flags[k];
    end
    sel_ok = (cmd == CMD_CHECK) && (32'(key_sel) < NUM_KEYS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      flags <= sel_ok ? sel_flags : '0;
      hit   <= sel_ok && ((sel_flags & flag_mask) != '0);
    end
  end

endmodule

// ----- sim/multi_key_click_event_detector_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-key click event detector testbench
// Drives tick, check and clear items with random idling on both channels and
// checks every result item against a cycle-free model of the key machines.
// The run walks a short directed table, then random key gestures under a
// series of timing settings that include both extremes of every register.
// ----------------------------------------------------------------------------
module multi_key_click_event_detector_unit_test;
  import mkced_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int KEYS = NUM_KEYS_DEF;
  localparam int LIMIT = 200000;
  localparam int HOLD_OFF = 64;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 235;
  localparam int DIR_ROWS = 29;

  typedef struct packed {
    logic              hit;
    logic [FLAG_W-1:0] flags;
  } click_res_t;

  typedef struct packed {
    logic              is_reg;
    logic [1:0]        op;
    logic [2:0]        lv;
    logic [1:0]        sel;
    logic [FLAG_W-1:0] mask;
    logic [7:0]        reps;
    logic              known;
    logic              e_hit;
    logic [FLAG_W-1:0] e_flags;
    logic [CNT_W-1:0]  data;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          cmd = CMD_TICK;
  logic [LEVEL_W-1:0]  key_levels = '0;
  logic [1:0]          key_sel = '0;
  logic [FLAG_W-1:0]   flag_mask = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                hit;
  logic [FLAG_W-1:0]   flags;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = REG_SAMPLE_PERIOD;
  logic [CNT_W-1:0]    cfg_data = '0;

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int cycle_cnt = 0;
  int err_cnt = 0;
  int item_cnt = 0;
  int result_cnt = 0;
  logic [FLAG_W-1:0] seen_flags = '0;

  click_res_t pending_q[$];

  // Timing registers and key state as the block should hold them.
  logic [7:0]        sample_gap;
  logic [CNT_W-1:0]  long_hold;
  logic [CNT_W-1:0]  dbl_window;
  logic [CNT_W-1:0]  rep_gap;
  logic [7:0]        tick_div;
  logic [KEYS-1:0]   lvl_prev;
  logic [KEYS-1:0]   lvl_now;
  logic [2:0]        key_state [KEYS];
  logic [CNT_W-1:0]  key_timer [KEYS];
  logic [FLAG_W-1:0] key_evt [KEYS];

  plan_row_t dir_plan [DIR_ROWS] = '{
    '{1'b0, CMD_CHECK, 3'd0, 2'd0, 7'h7f, 8'd1, 1'b1, 1'b0, 7'h00, 16'd0},
    '{1'b0, CMD_NONE, 3'd7, 2'd3, 7'h7f, 8'd1, 1'b1, 1'b0, 7'h00, 16'd0},
    '{1'b0, CMD_CLEAR, 3'd7, 2'd1, 7'h7f, 8'd1, 1'b1, 1'b0, 7'h00, 16'd0},
    '{1'b0, CMD_CHECK, 3'd5, 2'd3, 7'h7f, 8'd1, 1'b1, 1'b0, 7'h00, 16'd0},
    '{1'b0, CMD_TICK, 3'd7, 2'd0, 7'h00, 8'd19, 1'b1, 1'b0, 7'h00, 16'd0},
    '{1'b0, CMD_TICK, 3'd7, 2'd0, 7'h00, 8'd1, 1'b1, 1'b0, 7'h00, 16'd0},
    '{1'b0, CMD_CHECK, 3'd0, 2'd0, FL_HOLD, 8'd1, 1'b1, 1'b1, 7'h03, 16'd0},
    '{1'b0, CMD_CHECK, 3'd0, 2'd0, FL_DOWN, 8'd1, 1'b1, 1'b1, 7'h03, 16'd0},
    '{1'b0, CMD_CHECK, 3'd0, 2'd0, FL_DOWN, 8'd1, 1'b1, 1'b0, 7'h01, 16'd0},
    '{1'b1, REG_SAMPLE_PERIOD, 3'd0, 2'd0, 7'h00, 8'd0, 1'b0, 1'b0, 7'h00, 16'hab00},
    '{1'b1, REG_LONG_PRESS, 3'd0, 2'd0, 7'h00, 8'd0, 1'b0, 1'b0, 7'h00, 16'd2},
    '{1'b1, REG_DOUBLE_CLICK, 3'd0, 2'd0, 7'h00, 8'd0, 1'b0, 1'b0, 7'h00, 16'd2},
    '{1'b1, REG_REPEAT, 3'd0, 2'd0, 7'h00, 8'd0, 1'b0, 1'b0, 7'h00, 16'd1},
    '{1'b0, CMD_TICK, 3'd0, 2'd0, 7'h00, 8'd3, 1'b1, 1'b0, 7'h00, 16'd0},
    '{1'b0, CMD_CHECK, 3'd0, 2'd0, 7'h7f, 8'd1, 1'b0, 1'b0, 7'h00, 16'd0},
    '{1'b0, CMD_CHECK, 3'd0, 2'd1, 7'h00, 8'd1, 1'b0, 1'b0, 7'h00, 16'd0},
    '{1'b0, CMD_CLEAR, 3'd0, 2'd0, 7'h00, 8'd1, 1'b1, 1'b0, 7'h00, 16'd0},
    '{1'b0, CMD_TICK, 3'd1, 2'd0, 7'h00, 8'd5, 1'b1, 1'b0, 7'h00, 16'd0},
    '{1'b0, CMD_CHECK, 3'd0, 2'd0, FL_HOLD, 8'd1, 1'b0, 1'b0, 7'h00, 16'd0},
    '{1'b0, CMD_CHECK, 3'd0, 2'd0, FL_LONG | FL_REPEAT, 8'd1, 1'b0, 1'b0, 7'h00, 16'd0},
    '{1'b0, CMD_TICK, 3'd0, 2'd0, 7'h00, 8'd1, 1'b1, 1'b0, 7'h00, 16'd0},
    '{1'b0, CMD_TICK, 3'd2, 2'd0, 7'h00, 8'd1, 1'b1, 1'b0, 7'h00, 16'd0},
    '{1'b0, CMD_TICK, 3'd0, 2'd0, 7'h00, 8'd1, 1'b1, 1'b0, 7'h00, 16'd0},
    '{1'b0, CMD_TICK, 3'd2, 2'd0, 7'h00, 8'd1, 1'b1, 1'b0, 7'h00, 16'd0},
    '{1'b0, CMD_TICK, 3'd6, 2'd0, 7'h00, 8'd1, 1'b1, 1'b0, 7'h00, 16'd0},
    '{1'b0, CMD_TICK, 3'd0, 2'd0, 7'h00, 8'd1, 1'b1, 1'b0, 7'h00, 16'd0},
    '{1'b0, CMD_CHECK, 3'd0, 2'd1, 7'h7f, 8'd1, 1'b0, 1'b0, 7'h00, 16'd0},
    '{1'b0, CMD_CHECK, 3'd0, 2'd2, 7'h7f, 8'd1, 1'b0, 1'b0, 7'h00, 16'd0},
    '{1'b0, CMD_CHECK, 3'd0, 2'd0, 7'h7f, 8'd1, 1'b0, 1'b0, 7'h00, 16'd0}
  };

  // Sample period, long press, double click window, repeat interval.
  logic [CNT_W-1:0] timing_plan [PHASES][4] = '{
    '{16'd1, 16'd6, 16'd4, 16'd2},
    '{16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd2, 16'd12, 16'd8, 16'd3},
    '{16'd255, 16'd65535, 16'd65535, 16'd65535},
    '{16'd1, 16'd3, 16'd5, 16'd1},
    '{16'd20, 16'd2000, 16'd200, 16'd100},
    '{16'd3, 16'd0, 16'd65535, 16'd0},
    '{16'd4, 16'd20, 16'd0, 16'd5}
  };

  multi_key_click_event_detector_unit u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void load_timing(logic [1:0] idx, logic [CNT_W-1:0] val);
    case (idx)
      REG_SAMPLE_PERIOD: sample_gap = val[7:0];
      REG_LONG_PRESS:    long_hold = val;
      REG_DOUBLE_CLICK:  dbl_window = val;
      REG_REPEAT:        rep_gap = val;
      default: ;
    endcase
  endfunction

  function automatic void sample_key(int k, logic lv);
    logic [FLAG_W-1:0] f;
    logic was;
    f = key_evt[k];
    lvl_prev[k] = lvl_now[k];
    lvl_now[k] = lv;
    was = lvl_prev[k];
    case (key_state[k]) inside
      PH_IDLE: begin
        if (lv) begin
          key_timer[k] = long_hold;
          f |= FL_HOLD;
          key_state[k] = PH_PRESSED;
          if (!was) f |= FL_DOWN;
        end
      end
      PH_PRESSED: begin
        if (!lv) begin
          key_timer[k] = dbl_window;
          f &= ~FL_HOLD;
          key_state[k] = PH_RELEASED;
          if (was) f |= FL_UP;
        end else if (key_timer[k] == '0) begin
          f |= FL_LONG;
          key_state[k] = PH_LONG;
        end
      end
      PH_RELEASED: begin
        if (key_timer[k] == '0) begin
          f |= FL_SINGLE;
          key_state[k] = PH_IDLE;
        end else if (lv) begin
          f |= FL_DOUBLE | FL_HOLD;
          key_state[k] = PH_DOUBLE;
        end
        if (lv && !was) f |= FL_DOWN;
      end
      PH_DOUBLE, PH_LONG: begin
        if (!lv) begin
          f &= ~FL_HOLD;
          key_state[k] = PH_IDLE;
          if (was) f |= FL_UP;
        end else if (key_state[k] == PH_LONG && key_timer[k] == '0) begin
          key_timer[k] = rep_gap;
          f |= FL_REPEAT;
        end
      end
      default: key_state[k] = PH_IDLE;
    endcase
    key_evt[k] = f;
  endfunction

  function automatic click_res_t predict_click(logic [1:0] op, logic [2:0] lv,
                                               logic [1:0] sel, logic [FLAG_W-1:0] mask);
    click_res_t r;
    logic [8:0] nxt;
    r = '0;
    case (op)
      CMD_TICK: begin
        for (int k = 0; k < KEYS; k++) begin
          if (key_timer[k] != '0) key_timer[k] = key_timer[k] - 1'b1;
        end
        nxt = {1'b0, tick_div} + 9'd1;
        if (nxt >= {1'b0, sample_gap}) begin
          tick_div = '0;
          for (int k = 0; k < KEYS; k++) sample_key(k, lv[k]);
        end else begin
          tick_div = nxt[7:0];
        end
      end
      CMD_CHECK: begin
        if (int'(sel) < KEYS) begin
          r.flags = key_evt[sel];
          if ((r.flags & mask) != '0) begin
            r.hit = 1'b1;
            if (mask != FL_HOLD) key_evt[sel] = r.flags & ~mask;
          end
        end
      end
      CMD_CLEAR: begin
        for (int k = 0; k < KEYS; k++) key_evt[k] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic offer(input logic [1:0] op, input logic [2:0] lv, input logic [1:0] sel,
                       input logic [FLAG_W-1:0] mask);
    logic taken;
    while (!calm && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    key_levels <= lv;
    key_sel <= sel;
    flag_mask <= mask;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    if (op != CMD_NONE) item_cnt++;
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [CNT_W-1:0] val);
    logic done;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    done = 1'b0;
    while (!done) begin
      @(negedge clk);
      done = cfg_ready;
      @(posedge clk);
    end
    load_timing(idx, val);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Result side: random stalls, one long hold-off on request, in-order check.
  initial begin
    logic took;
    click_res_t got;
    click_res_t want;
    int hold_left;
    took = 1'b0;
    hold_left = 0;
    got = '0;
    forever begin
      @(posedge clk);
      if (took) begin
        result_cnt++;
        seen_flags |= got.flags;
        if (pending_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result item: hit=%0d flags=%02h", got.hit, got.flags);
        end else begin
          want = pending_q.pop_front();
          if (want.hit !== got.hit || want.flags !== got.flags) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch at result %0d: expected hit=%0d flags=%02h, got hit=%0d flags=%02h",
                       result_cnt, want.hit, want.flags, got.hit, got.flags);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_OFF - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 19);
      end
      @(negedge clk);
      took = (out_valid === 1'b1) && !out_stall;
      got.hit = hit;
      got.flags = flags;
    end
  end

  initial begin
    plan_row_t row;
    click_res_t guess;
    logic [2:0] held;
    logic [1:0] op;
    logic [2:0] lv;
    logic [1:0] sel;
    logic [FLAG_W-1:0] mask;
    int roll;
    int cnt;

    sample_gap = SAMPLE_PERIOD_RST;
    long_hold = LONG_PRESS_RST;
    dbl_window = DOUBLE_CLICK_RST;
    rep_gap = REPEAT_RST;
    tick_div = '0;
    lvl_prev = '0;
    lvl_now = '0;
    for (int k = 0; k < KEYS; k++) begin
      key_state[k] = PH_IDLE;
      key_timer[k] = '0;
      key_evt[k] = '0;
    end
    held = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_plan[i];
      if (row.is_reg) begin
        drain();
        set_reg(row.op, row.data);
        cfg_valid <= 1'b0;
      end else begin
        repeat (row.reps) begin
          offer(row.op, row.lv, row.sel, row.mask);
          guess = predict_click(row.op, row.lv, row.sel, row.mask);
          if (row.known) begin
            guess.hit = row.e_hit;
            guess.flags = row.e_flags;
          end
          pending_q.push_back(guess);
        end
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      set_reg(REG_SAMPLE_PERIOD, {8'($urandom_range(0, 255)), timing_plan[p][0][7:0]});
      set_reg(REG_LONG_PRESS, timing_plan[p][1]);
      set_reg(REG_DOUBLE_CLICK, timing_plan[p][2]);
      set_reg(REG_REPEAT, timing_plan[p][3]);
      cfg_valid <= 1'b0;
      calm = (p == 4);
      if (p == 2) hold_req = 1'b1;
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        lv = 3'($urandom_range(0, 7));
        sel = 2'($urandom_range(0, 3));
        mask = 7'($urandom_range(0, 127));
        if (roll < 68) begin
          op = CMD_TICK;
          if ($urandom_range(0, 3) == 0) held = held ^ (3'b001 << $urandom_range(0, 2));
          if ($urandom_range(0, 9) != 0) lv = held;
        end else if (roll < 92) begin
          op = CMD_CHECK;
          sel = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
          roll = $urandom_range(0, 9);
          if (roll < 4) mask = 7'h7f;
          else if (roll < 7) mask = 7'b1 << $urandom_range(0, 6);
          else if (roll < 8) mask = FL_HOLD;
        end else if (roll < 97) begin
          op = CMD_CLEAR;
        end else begin
          op = CMD_NONE;
        end
        offer(op, lv, sel, mask);
        pending_q.push_back(predict_click(op, lv, sel, mask));
        if (op != CMD_NONE) cnt++;
      end
    end
    calm = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    $display("run covered %0d items and %0d result items over %0d timing settings",
             item_cnt, result_cnt, PHASES + 2);
    $display("flag bits seen in results: %07b, mismatches: %0d", seen_flags, err_cnt);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
